[design/tepq_pkg.sv]
package tepq_pkg;

    localparam int unsigned FIELD_TIME_W = 16;
    localparam int unsigned FIELD_KIND_W = 3;
    localparam int unsigned FIELD_TAG_W  = 16;
    localparam int unsigned OCC_W        = 7;
    localparam int unsigned RANK_W       = 4;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [FIELD_KIND_W-1:0] {
        KIND_CANCEL  = 3'd0,
        KIND_PROMOTE = 3'd1,
        KIND_ACCIDENT = 3'd2,
        KIND_CLOSURE = 3'd3,
        KIND_ARRIVAL = 3'd4,
        KIND_UNBLOCK = 3'd5,
        KIND_REOPEN  = 3'd6,
        KIND_OTHER   = 3'd7
    } t_kind;

    localparam logic [RANK_W-1:0] RANK_CANCEL  = 4'd1;
    localparam logic [RANK_W-1:0] RANK_PROMOTE = 4'd2;
    localparam logic [RANK_W-1:0] RANK_INCIDENT = 4'd3;
    localparam logic [RANK_W-1:0] RANK_ARRIVAL = 4'd4;
    localparam logic [RANK_W-1:0] RANK_UNBLOCK = 4'd5;
    localparam logic [RANK_W-1:0] RANK_OTHER   = 4'd10;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

    function automatic logic [RANK_W-1:0] kind_rank(input logic [FIELD_KIND_W-1:0] kind);
        logic [RANK_W-1:0] rank;
        case (kind)
            KIND_CANCEL:   rank = RANK_CANCEL;
            KIND_PROMOTE:  rank = RANK_PROMOTE;
            KIND_ACCIDENT: rank = RANK_INCIDENT;
            KIND_CLOSURE:  rank = RANK_INCIDENT;
            KIND_ARRIVAL:  rank = RANK_ARRIVAL;
            KIND_UNBLOCK:  rank = RANK_UNBLOCK;
            KIND_REOPEN:   rank = RANK_UNBLOCK;
            default:       rank = RANK_OTHER;
        endcase
        return rank;
    endfunction

    function automatic logic key_less(
        input logic [FIELD_TIME_W-1:0] ta,
        input logic [FIELD_KIND_W-1:0] ka,
        input logic [FIELD_TIME_W-1:0] tb,
        input logic [FIELD_KIND_W-1:0] kb
    );
        logic res;
        if (ta != tb) begin
            res = ta < tb;
        end else begin
            res = kind_rank(ka) < kind_rank(kb);
        end
        return res;
    endfunction

endpackage

[design/tepq_cell.sv]
module tepq_cell #(
    parameter int unsigned CELL_IDX = 0,
    parameter int unsigned TW       = 16,
    parameter int unsigned CW       = 7
) (
    input  logic                            i_clk,
    input  tepq_pkg::t_cell_ctl             i_ctl,
    input  logic [CW-1:0]                   i_cnt,
    input  logic [TW-1:0]                   i_new_time,
    input  logic [tepq_pkg::FIELD_KIND_W-1:0] i_new_kind,
    input  logic [tepq_pkg::FIELD_TAG_W-1:0]  i_new_tag,
    input  logic                            i_place_left,
    input  logic [TW-1:0]                   i_left_time,
    input  logic [tepq_pkg::FIELD_KIND_W-1:0] i_left_kind,
    input  logic [tepq_pkg::FIELD_TAG_W-1:0]  i_left_tag,
    input  logic [TW-1:0]                   i_right_time,
    input  logic [tepq_pkg::FIELD_KIND_W-1:0] i_right_kind,
    input  logic [tepq_pkg::FIELD_TAG_W-1:0]  i_right_tag,
    output logic                            o_place,
    output logic [TW-1:0]                   o_time,
    output logic [tepq_pkg::FIELD_KIND_W-1:0] o_kind,
    output logic [tepq_pkg::FIELD_TAG_W-1:0]  o_tag
);
    import tepq_pkg::*;

    logic [TW-1:0]           r_time, n_time;
    logic [FIELD_KIND_W-1:0] r_kind, n_kind;
    logic [FIELD_TAG_W-1:0]  r_tag, n_tag;
    logic                    w_valid;
    logic                    w_at_end;
    logic                    w_new_less;

    // The new event goes in front of this entry when its key is strictly smaller.
    assign w_valid    = CW'(CELL_IDX) < i_cnt;
    assign w_at_end   = CW'(CELL_IDX) == i_cnt;
    assign w_new_less = key_less(FIELD_TIME_W'(i_new_time), i_new_kind,
                                 FIELD_TIME_W'(r_time), r_kind);
    assign o_place    = (w_valid && w_new_less) || w_at_end;

    always_comb begin
        n_time = r_time;
        n_kind = r_kind;
        n_tag  = r_tag;
        if (i_ctl.ins) begin
            if (i_place_left) begin
                n_time = i_left_time;
                n_kind = i_left_kind;
                n_tag  = i_left_tag;
            end else if (o_place) begin
                n_time = i_new_time;
                n_kind = i_new_kind;
                n_tag  = i_new_tag;
            end
        end else if (i_ctl.pop) begin
            n_time = i_right_time;
            n_kind = i_right_kind;
            n_tag  = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_kind <= n_kind;
        r_tag  <= n_tag;
    end

    assign o_time = r_time;
    assign o_kind = r_kind;
    assign o_tag  = r_tag;

endmodule

[design/timed_event_priority_queue_top.sv]
// Sorted event queue built as a row of QUEUE_DEPTH cells, ordered by (time, class rank) with
// equal keys kept in arrival order; cell 0 always holds the head. Each input beat is either an
// insert (tuser 0) or a pop at the current time (tuser 1), and yields exactly one output beat
// in the next cycle. Every cell compares the incoming key against its own entry in parallel
// and the whole row shifts in the same cycle, so one beat is taken every clock; the input
// stalls only while the output register holds a beat that the downstream side has not taken.
// Stored times keep the low TIME_BITS bits of the input time (at most 16). An insert into a
// full queue is dropped with status 1, and a pop of an empty queue reports status 2.
module timed_event_priority_queue_top #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned TIME_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // event_time[15:0], event_kind[18:16], event_tag[34:19]
    input  logic        i_s_axis_tuser,  // op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // out_time[15:0], out_kind[18:16], out_tag[34:19],
                                         // status[36:35], occupancy[43:37]
    output logic        o_m_axis_tuser   // popped
);
    import tepq_pkg::*;

    localparam int unsigned TW = (TIME_BITS < FIELD_TIME_W) ? TIME_BITS : FIELD_TIME_W;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned LAST = QUEUE_DEPTH - 1;

    logic [TW-1:0]           w_time  [QUEUE_DEPTH];
    logic [FIELD_KIND_W-1:0] w_kind  [QUEUE_DEPTH];
    logic [FIELD_TAG_W-1:0]  w_tag   [QUEUE_DEPTH];
    logic                    w_place [QUEUE_DEPTH];

    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_out_valid;
    logic                    r_popped;
    logic [FIELD_TIME_W-1:0] r_otime;
    logic [FIELD_KIND_W-1:0] r_okind;
    logic [FIELD_TAG_W-1:0]  r_otag;
    t_status                 r_status, n_status;
    logic [OCC_W-1:0]        r_occ;

    logic                    w_acc;
    t_op                     w_op;
    logic [TW-1:0]           w_in_time;
    logic [FIELD_KIND_W-1:0] w_in_kind;
    logic [FIELD_TAG_W-1:0]  w_in_tag;
    logic                    w_full;
    logic                    w_empty;
    t_cell_ctl               w_ctl;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op      = t_op'(i_s_axis_tuser);
    assign w_in_time = i_s_axis_tdata[TW-1:0];
    assign w_in_kind = i_s_axis_tdata[18:16];
    assign w_in_tag  = i_s_axis_tdata[34:19];

    assign w_full  = r_cnt == CW'(QUEUE_DEPTH);
    assign w_empty = r_cnt == '0;

    assign w_ctl.ins = w_acc && (w_op == OP_INSERT) && !w_full;
    assign w_ctl.pop = w_acc && (w_op == OP_POP) && !w_empty && (w_time[0] == w_in_time);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic                    w_pl;
            logic [TW-1:0]           w_lt, w_rt;
            logic [FIELD_KIND_W-1:0] w_lk, w_rk;
            logic [FIELD_TAG_W-1:0]  w_lg, w_rg;

            if (gi == 0) begin : g_first
                assign w_pl = 1'b0;
                assign w_lt = '0;
                assign w_lk = '0;
                assign w_lg = '0;
            end else begin : g_mid
                assign w_pl = w_place[gi-1];
                assign w_lt = w_time[gi-1];
                assign w_lk = w_kind[gi-1];
                assign w_lg = w_tag[gi-1];
            end

            if (gi == LAST) begin : g_last
                assign w_rt = '0;
                assign w_rk = '0;
                assign w_rg = '0;
            end else begin : g_inner
                assign w_rt = w_time[gi+1];
                assign w_rk = w_kind[gi+1];
                assign w_rg = w_tag[gi+1];
            end

            tepq_cell #(
                .CELL_IDX(gi),
                .TW      (TW),
                .CW      (CW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_cnt       (r_cnt),
                .i_new_time  (w_in_time),
                .i_new_kind  (w_in_kind),
                .i_new_tag   (w_in_tag),
                .i_place_left(w_pl),
                .i_left_time (w_lt),
                .i_left_kind (w_lk),
                .i_left_tag  (w_lg),
                .i_right_time(w_rt),
                .i_right_kind(w_rk),
                .i_right_tag (w_rg),
                .o_place     (w_place[gi]),
                .o_time      (w_time[gi]),
                .o_kind      (w_kind[gi]),
                .o_tag       (w_tag[gi])
            );
        end
    endgenerate

    always_comb begin
        n_cnt    = r_cnt;
        n_status = ST_OK;
        if (w_ctl.ins) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_ctl.pop) begin
            n_cnt = r_cnt - 1'b1;
        end
        if (w_acc && (w_op == OP_INSERT) && w_full) begin
            n_status = ST_FULL;
        end else if (w_acc && (w_op == OP_POP) && w_empty) begin
            n_status = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_popped <= w_ctl.pop;
            r_otime  <= w_ctl.pop ? FIELD_TIME_W'(w_time[0]) : '0;
            r_okind  <= w_ctl.pop ? w_kind[0] : '0;
            r_otag   <= w_ctl.pop ? w_tag[0] : '0;
            r_status <= n_status;
            r_occ    <= OCC_W'(n_cnt);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_popped;
    assign o_m_axis_tdata  = {4'b0, r_occ, r_status, r_otag, r_okind, r_otime};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QUEUE_DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt >= CW'(2) |-> !key_less(FIELD_TIME_W'(w_time[1]), w_kind[1],
                                      FIELD_TIME_W'(w_time[0]), w_kind[0]))
        else $error("Second entry sorts ahead of the head.");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> r_out_valid && r_popped && (r_status == ST_OK))
        else $error("Removed head was not reported as popped.");

    a_full_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (w_op == OP_INSERT) && w_full |=> (r_cnt == CW'(QUEUE_DEPTH))
            && (r_status == ST_FULL))
        else $error("Insert into a full queue changed the occupancy.");

endmodule
